// ===== rtl/clr_pkg.sv =====
// Shared types and constants for the clipped line rasterizer.
// No dependencies; imported by every module in rtl/.
`timescale 1ns / 1ps

package clr_pkg;

    localparam int COORD_BITS   = 12;
    localparam int DELTA_BITS   = COORD_BITS + 1;
    localparam int ERR_BITS     = COORD_BITS + 2;
    localparam int REG_BITS     = 12;
    localparam int ADDR_BITS    = 22;
    localparam int CFG_IDX_BITS = 1;
    localparam int COLOR_BITS   = 32;
    localparam int CMP_BITS     = (COORD_BITS > REG_BITS) ? COORD_BITS : REG_BITS;
    localparam int MUL_BITS     = (COORD_BITS + REG_BITS > ADDR_BITS) ?
                                  (COORD_BITS + REG_BITS) : ADDR_BITS;

    localparam logic [REG_BITS-1:0] WIDTH_RESET  = REG_BITS'(640);
    localparam logic [REG_BITS-1:0] HEIGHT_RESET = REG_BITS'(480);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SURFACE_WIDTH  = 1'b0,
        CFG_SURFACE_HEIGHT = 1'b1
    } cfg_index_t;

    typedef enum logic {
        MODE_LINE = 1'b0,
        MODE_TICK = 1'b1
    } mode_t;

    typedef struct packed {
        logic                         mode;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic [COLOR_BITS-1:0]        line_color;
    } cmd_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [COLOR_BITS-1:0]        color;
        logic                         last;
    } walk_pix_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] pixel_x;
        logic signed [COORD_BITS-1:0] pixel_y;
        logic [ADDR_BITS-1:0]         pixel_address;
        logic [COLOR_BITS-1:0]        pixel_rgba;
        logic                         write_enable;
        logic                         last_pixel;
    } pixel_t;

endpackage

// ===== rtl/clipped_line_rasterizer.sv =====
// Top level of the clipped line rasterizer: configuration registers and the
// walker and address stages. Depends on clr_pkg, clr_walker, clr_addr_stage.
`timescale 1ns / 1ps

// Usage:
//   cmd (valid/ready): mode LINE loads start, end and color and starts a line,
//   dropping any line in progress; mode TICK emits the next pixel while a line
//   is active and is swallowed with no result while idle.
//   pixel (valid/ready): x, y, clip flag, address y*width+x (zero if clipped),
//   color and a last flag on the end pixel.
//   cfg: write surface_width (index 0) or surface_height (index 1) while idle.
// Timing:
//   A tick request's pixel passes through the walker's pixel register and then
//   the output register before it is valid on the pixel port. One request per
//   cycle is accepted while the pixel receiver does not stall; the walker's step
//   is the loop that sets this rate.
//   When the pixel receiver stalls, both registers hold and cmd_ready drops
//   once they are full; nothing is lost.
// Reset: walker idle, no pending pixel, width 640, height 480.

module clipped_line_rasterizer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  clr_pkg::cmd_t                     cmd,
    output logic                              pixel_valid,
    input  logic                              pixel_ready,
    output clr_pkg::pixel_t                   pixel,
    input  logic                              cfg_we,
    input  logic [clr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [clr_pkg::REG_BITS-1:0]      cfg_data
);
    import clr_pkg::*;

    logic [REG_BITS-1:0] width_reg, width_next;
    logic [REG_BITS-1:0] height_reg, height_next;

    logic      walk_valid;
    logic      walk_ready;
    walk_pix_t walk_pix;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SURFACE_WIDTH:  width_next  = cfg_data;
                CFG_SURFACE_HEIGHT: height_next = cfg_data;
                default:            width_next  = width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    clr_walker u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .walk_valid (walk_valid),
        .walk_ready (walk_ready),
        .walk_pix   (walk_pix)
    );

    clr_addr_stage u_addr (
        .clk            (clk),
        .rst_n          (rst_n),
        .surface_width  (width_reg),
        .surface_height (height_reg),
        .walk_valid     (walk_valid),
        .walk_ready     (walk_ready),
        .walk_pix       (walk_pix),
        .pixel_valid    (pixel_valid),
        .pixel_ready    (pixel_ready),
        .pixel          (pixel)
    );

endmodule

// ===== rtl/clr_walker.sv =====
// Bresenham walker: loads line requests, steps one pixel per tick request.
// Depends on clr_pkg; feeds clr_addr_stage through a registered pixel stage.
`timescale 1ns / 1ps

module clr_walker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  clr_pkg::cmd_t       cmd,
    output logic                walk_valid,
    input  logic                walk_ready,
    output clr_pkg::walk_pix_t  walk_pix
);
    import clr_pkg::*;

    logic                         busy_reg, busy_next;
    logic signed [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic signed [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic signed [COORD_BITS-1:0] tgt_x_reg, tgt_x_next;
    logic signed [COORD_BITS-1:0] tgt_y_reg, tgt_y_next;
    logic [DELTA_BITS-1:0]        dx_reg, dx_next;
    logic [DELTA_BITS-1:0]        dy_reg, dy_next;
    logic [1:0]                   dirs_reg, dirs_next;
    logic signed [ERR_BITS-1:0]   err_reg, err_next;
    logic [COLOR_BITS-1:0]        color_reg, color_next;
    logic                         s1_valid_reg, s1_valid_next;
    walk_pix_t                    s1_reg, s1_next;

    logic                         accept;
    logic                         tick_take;
    logic                         at_end;
    logic signed [DELTA_BITS-1:0] diff_x, diff_y;
    logic [DELTA_BITS-1:0]        abs_x, abs_y;
    logic signed [ERR_BITS:0]     e2, neg_dy, dx_s;
    logic                         step_x, step_y;
    logic signed [ERR_BITS:0]     err_upd;

    assign cmd_ready  = !s1_valid_reg || walk_ready;
    assign accept     = cmd_valid && cmd_ready;
    assign tick_take  = accept && (cmd.mode == MODE_TICK) && busy_reg;
    assign at_end     = (cur_x_reg == tgt_x_reg) && (cur_y_reg == tgt_y_reg);
    assign walk_valid = s1_valid_reg;
    assign walk_pix   = s1_reg;

    always_comb
    begin
        diff_x = DELTA_BITS'(cmd.end_x) - DELTA_BITS'(cmd.start_x);
        diff_y = DELTA_BITS'(cmd.end_y) - DELTA_BITS'(cmd.start_y);
        abs_x  = diff_x[DELTA_BITS-1] ? DELTA_BITS'(-diff_x) : DELTA_BITS'(diff_x);
        abs_y  = diff_y[DELTA_BITS-1] ? DELTA_BITS'(-diff_y) : DELTA_BITS'(diff_y);

        e2      = (ERR_BITS+1)'(err_reg) <<< 1;
        neg_dy  = -$signed({1'b0, (ERR_BITS)'(dy_reg)});
        dx_s    = $signed({1'b0, (ERR_BITS)'(dx_reg)});
        step_x  = e2 > neg_dy;
        step_y  = e2 < dx_s;
        err_upd = (ERR_BITS+1)'(err_reg);
        if (step_x)
        begin
            err_upd = err_upd + neg_dy;
        end
        if (step_y)
        begin
            err_upd = err_upd + dx_s;
        end

        busy_next     = busy_reg;
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        tgt_x_next    = tgt_x_reg;
        tgt_y_next    = tgt_y_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        dirs_next     = dirs_reg;
        err_next      = err_reg;
        color_next    = color_reg;
        s1_valid_next = s1_valid_reg && !walk_ready;
        s1_next       = s1_reg;

        if (accept)
        begin
            s1_valid_next = tick_take;
        end

        if (accept && cmd.mode == MODE_LINE)
        begin
            busy_next  = 1'b1;
            cur_x_next = cmd.start_x;
            cur_y_next = cmd.start_y;
            tgt_x_next = cmd.end_x;
            tgt_y_next = cmd.end_y;
            dx_next    = abs_x;
            dy_next    = abs_y;
            dirs_next  = {!(cmd.start_y < cmd.end_y), !(cmd.start_x < cmd.end_x)};
            err_next   = ERR_BITS'(abs_x) - ERR_BITS'(abs_y);
            color_next = cmd.line_color;
        end
        else if (tick_take)
        begin
            s1_next.x     = cur_x_reg;
            s1_next.y     = cur_y_reg;
            s1_next.color = color_reg;
            s1_next.last  = at_end;
            if (at_end)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                err_next = ERR_BITS'(err_upd);
                if (step_x)
                begin
                    cur_x_next = dirs_reg[0] ? cur_x_reg - COORD_BITS'(1)
                                             : cur_x_reg + COORD_BITS'(1);
                end
                if (step_y)
                begin
                    cur_y_next = dirs_reg[1] ? cur_y_reg - COORD_BITS'(1)
                                             : cur_y_reg + COORD_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            cur_x_reg    <= '0;
            cur_y_reg    <= '0;
            tgt_x_reg    <= '0;
            tgt_y_reg    <= '0;
            dx_reg       <= '0;
            dy_reg       <= '0;
            dirs_reg     <= '0;
            err_reg      <= '0;
            color_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            cur_x_reg    <= cur_x_next;
            cur_y_reg    <= cur_y_next;
            tgt_x_reg    <= tgt_x_next;
            tgt_y_reg    <= tgt_y_next;
            dx_reg       <= dx_next;
            dy_reg       <= dy_next;
            dirs_reg     <= dirs_next;
            err_reg      <= err_next;
            color_reg    <= color_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
    end

`ifndef SYNTHESIS
    a_end_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_take && at_end) |=> !busy_reg)
        else $error("walker stayed busy after the end pixel");

    a_busy_from_line: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy_reg) |-> $past(accept && cmd.mode == MODE_LINE))
        else $error("walker became busy without a line request");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !walk_ready) |=> (s1_valid_reg && $stable(s1_reg)))
        else $error("pixel stage changed while stalled");
`endif

endmodule

// ===== rtl/clr_addr_stage.sv =====
// Clip test and linear address for one walked pixel, into the output register.
// Depends on clr_pkg; takes pixels from clr_walker.
`timescale 1ns / 1ps

module clr_addr_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [clr_pkg::REG_BITS-1:0]  surface_width,
    input  logic [clr_pkg::REG_BITS-1:0]  surface_height,
    input  logic                          walk_valid,
    output logic                          walk_ready,
    input  clr_pkg::walk_pix_t            walk_pix,
    output logic                          pixel_valid,
    input  logic                          pixel_ready,
    output clr_pkg::pixel_t               pixel
);
    import clr_pkg::*;

    logic   out_valid_reg, out_valid_next;
    pixel_t out_reg, out_next;

    logic                 in_bounds;
    logic [CMP_BITS-1:0]  x_u, y_u, w_u, h_u;
    logic [MUL_BITS-1:0]  prod;

    assign walk_ready  = !out_valid_reg || pixel_ready;
    assign pixel_valid = out_valid_reg;
    assign pixel       = out_reg;

    always_comb
    begin
        x_u       = CMP_BITS'($unsigned(walk_pix.x));
        y_u       = CMP_BITS'($unsigned(walk_pix.y));
        w_u       = CMP_BITS'(surface_width);
        h_u       = CMP_BITS'(surface_height);
        in_bounds = !walk_pix.x[COORD_BITS-1] && !walk_pix.y[COORD_BITS-1]
                    && (x_u < w_u) && (y_u < h_u);
        prod      = MUL_BITS'(y_u) * MUL_BITS'(surface_width) + MUL_BITS'(x_u);

        out_next               = out_reg;
        out_valid_next         = out_valid_reg && !pixel_ready;
        if (walk_valid && walk_ready)
        begin
            out_valid_next         = 1'b1;
            out_next.pixel_x       = walk_pix.x;
            out_next.pixel_y       = walk_pix.y;
            out_next.pixel_address = in_bounds ? ADDR_BITS'(prod) : '0;
            out_next.pixel_rgba    = walk_pix.color;
            out_next.write_enable  = in_bounds;
            out_next.last_pixel    = walk_pix.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

`ifndef SYNTHESIS
    a_clipped_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.write_enable) |-> (out_reg.pixel_address == '0))
        else $error("clipped pixel carries a nonzero address");

    a_written_in_x: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.write_enable) |->
            (!out_reg.pixel_x[COORD_BITS-1] && !out_reg.pixel_y[COORD_BITS-1]))
        else $error("written pixel has a negative coordinate");
`endif

endmodule
